@@ rtl/cmef_pkg.sv @@
// ----------------------------------------------------------------------------
// cmef_pkg
// shared widths, register indexes, controller states and the command and
// status bundles of the clamp / median / ewma filter
// ----------------------------------------------------------------------------
package cmef_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WINDOW_MAX = 9;
  localparam int CNT_W      = 4;   // holds 0..WINDOW_MAX
  localparam int IDX_W      = 4;   // addresses WINDOW_MAX entries
  localparam int GAIN_W     = 17;
  localparam int FRAC_W     = 16;
  localparam int AVG_W      = SAMPLE_W + FRAC_W;
  localparam int DIFF_W     = AVG_W + 1;
  localparam int HI_W       = DIFF_W - FRAC_W;
  localparam int MUL_W      = HI_W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_LIMIT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LIMIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_GAIN = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] MIN_LIMIT_RST = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] MAX_LIMIT_RST = 16'sh7fff;
  localparam logic [CNT_W-1:0]           WINDOW_RST    = 4'd5;
  localparam logic [GAIN_W-1:0]          GAIN_RST      = 17'd16384;
  localparam logic [GAIN_W-1:0]          GAIN_ONE      = 17'h10000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EWMA,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_ACCUM,
    ST_PUBLISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic seed;
    logic diff;
    logic mul_hi;
    logic mul_lo;
    logic accum;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic seeded;
  } sts_t;

endpackage

@@ rtl/cmef_ctrl.sv @@
// ----------------------------------------------------------------------------
// cmef_ctrl
// sequencer for one request: load, rank scan, ewma update, publish
// ----------------------------------------------------------------------------
module cmef_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  cmef_pkg::sts_t  sts,
  output cmef_pkg::cmd_t  cmd
);

  cmef_pkg::state_t state;
  cmef_pkg::state_t state_next;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cmef_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cmef_pkg::ST_IDLE: begin
        if (in_valid && !in_stall) state_next = cmef_pkg::ST_SCAN;
      end
      cmef_pkg::ST_SCAN: begin
        if (sts.found) state_next = cmef_pkg::ST_EWMA;
      end
      cmef_pkg::ST_EWMA: begin
        state_next = sts.seeded ? cmef_pkg::ST_MUL_HI : cmef_pkg::ST_PUBLISH;
      end
      cmef_pkg::ST_MUL_HI:  state_next = cmef_pkg::ST_MUL_LO;
      cmef_pkg::ST_MUL_LO:  state_next = cmef_pkg::ST_ACCUM;
      cmef_pkg::ST_ACCUM:   state_next = cmef_pkg::ST_PUBLISH;
      cmef_pkg::ST_PUBLISH: begin
        if (out_free) state_next = cmef_pkg::ST_IDLE;
      end
      default: state_next = cmef_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = rst || (state != cmef_pkg::ST_IDLE);
    case (state)
      cmef_pkg::ST_IDLE:    cmd.load    = in_valid && !in_stall;
      cmef_pkg::ST_SCAN:    cmd.scan    = 1'b1;
      cmef_pkg::ST_EWMA: begin
        cmd.seed = !sts.seeded;
        cmd.diff = sts.seeded;
      end
      cmef_pkg::ST_MUL_HI:  cmd.mul_hi  = 1'b1;
      cmef_pkg::ST_MUL_LO:  cmd.mul_lo  = 1'b1;
      cmef_pkg::ST_ACCUM:   cmd.accum   = 1'b1;
      cmef_pkg::ST_PUBLISH: cmd.publish = out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/cmef_datapath.sv @@
// ----------------------------------------------------------------------------
// cmef_datapath
// configuration registers, clamp, sample window, rank scan, ewma arithmetic
// and the output payload registers
// ----------------------------------------------------------------------------
module cmef_datapath (
  input  logic                                     clk,
  input  logic                                     rst,
  input  cmef_pkg::cmd_t                           cmd,
  output cmef_pkg::sts_t                           sts,
  input  logic                                     cfg_write_en,
  input  logic [cmef_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [cmef_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic signed [cmef_pkg::SAMPLE_W-1:0]     sample,
  input  logic                                     sample_invalid,
  output logic signed [cmef_pkg::SAMPLE_W-1:0]     clamped_value,
  output logic signed [cmef_pkg::SAMPLE_W-1:0]     median_value,
  output logic signed [cmef_pkg::SAMPLE_W-1:0]     smoothed_value,
  output logic                                     window_full,
  output logic [cmef_pkg::CNT_W-1:0]               fill_count
);

  // configuration
  logic signed [cmef_pkg::SAMPLE_W-1:0] min_limit;
  logic signed [cmef_pkg::SAMPLE_W-1:0] max_limit;
  logic [cmef_pkg::CNT_W-1:0]           window_length;
  logic [cmef_pkg::GAIN_W-1:0]          smoothing_gain;
  logic [cmef_pkg::CNT_W-1:0]           wl_wr;
  logic [cmef_pkg::GAIN_W-1:0]          gain_wr;

  // window
  logic signed [cmef_pkg::SAMPLE_W-1:0] history [cmef_pkg::WINDOW_MAX];
  logic [cmef_pkg::IDX_W-1:0]           write_slot;
  logic [cmef_pkg::IDX_W-1:0]           write_slot_next;
  logic [cmef_pkg::CNT_W-1:0]           filled;
  logic [cmef_pkg::CNT_W-1:0]           filled_next;

  // clamp
  logic signed [cmef_pkg::SAMPLE_W:0]   limit_sum;
  logic signed [cmef_pkg::SAMPLE_W-1:0] clamp_v;
  logic signed [cmef_pkg::SAMPLE_W-1:0] clamp_reg;

  // rank scan
  logic [cmef_pkg::IDX_W-1:0]           cand;
  logic signed [cmef_pkg::SAMPLE_W-1:0] cand_val;
  logic [cmef_pkg::CNT_W-1:0]           less_cnt;
  logic [cmef_pkg::CNT_W-1:0]           leq_cnt;
  logic [cmef_pkg::CNT_W-1:0]           rank;
  logic signed [cmef_pkg::SAMPLE_W-1:0] median;

  // ewma
  logic signed [cmef_pkg::AVG_W-1:0]    average_q16;
  logic                                 average_seeded;
  logic signed [cmef_pkg::DIFF_W-1:0]   diff;
  logic signed [cmef_pkg::HI_W-1:0]     diff_hi;
  logic [cmef_pkg::FRAC_W-1:0]          diff_lo;
  logic signed [cmef_pkg::MUL_W-1:0]    mul_a;
  logic signed [cmef_pkg::MUL_W-1:0]    mul_b;
  logic signed [cmef_pkg::PROD_W-1:0]   product;
  logic signed [cmef_pkg::AVG_W-1:0]    prod_hi;
  logic [cmef_pkg::FRAC_W-1:0]          prod_lo;

  // register write saturation
  always_comb begin
    wl_wr = cfg_data[cmef_pkg::CNT_W-1:0];
    if (wl_wr == '0) begin
      wl_wr = cmef_pkg::CNT_W'(1);
    end else if (wl_wr > cmef_pkg::CNT_W'(cmef_pkg::WINDOW_MAX)) begin
      wl_wr = cmef_pkg::CNT_W'(cmef_pkg::WINDOW_MAX);
    end
    gain_wr = cfg_data[cmef_pkg::GAIN_W-1:0];
    if (gain_wr > cmef_pkg::GAIN_ONE) gain_wr = cmef_pkg::GAIN_ONE;
  end

  // invalid samples take the floored midpoint, otherwise lower bound wins first
  always_comb begin
    limit_sum = {min_limit[cmef_pkg::SAMPLE_W-1], min_limit}
              + {max_limit[cmef_pkg::SAMPLE_W-1], max_limit};
    if (sample_invalid) begin
      clamp_v = limit_sum[cmef_pkg::SAMPLE_W:1];
    end else if (sample < min_limit) begin
      clamp_v = min_limit;
    end else if (sample > max_limit) begin
      clamp_v = max_limit;
    end else begin
      clamp_v = sample;
    end
  end

  always_comb begin
    write_slot_next = write_slot + cmef_pkg::IDX_W'(1);
    if (write_slot_next == window_length) write_slot_next = '0;
    filled_next = (filled < window_length) ? filled + cmef_pkg::CNT_W'(1) : filled;
  end

  // candidate rank against all filled entries
  always_comb begin
    cand_val = history[cand];
    less_cnt = '0;
    leq_cnt  = '0;
    for (int j = 0; j < cmef_pkg::WINDOW_MAX; j++) begin
      if (cmef_pkg::CNT_W'(j) < filled) begin
        less_cnt = less_cnt + cmef_pkg::CNT_W'(history[j] <  cand_val);
        leq_cnt  = leq_cnt  + cmef_pkg::CNT_W'(history[j] <= cand_val);
      end
    end
    rank       = filled >> 1;
    sts.found  = (less_cnt <= rank) && (leq_cnt > rank);
    sts.seeded = average_seeded;
  end

  // q17.16 difference, split into an integer and a fraction half
  always_comb begin
    diff = {median[cmef_pkg::SAMPLE_W-1], median, {cmef_pkg::FRAC_W{1'b0}}}
         - {average_q16[cmef_pkg::AVG_W-1], average_q16};
    mul_a = cmd.mul_lo ? $signed({2'b00, diff_lo})
                       : $signed({diff_hi[cmef_pkg::HI_W-1], diff_hi});
    mul_b = $signed({1'b0, smoothing_gain});
    product = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_limit      <= cmef_pkg::MIN_LIMIT_RST;
      max_limit      <= cmef_pkg::MAX_LIMIT_RST;
      window_length  <= cmef_pkg::WINDOW_RST;
      smoothing_gain <= cmef_pkg::GAIN_RST;
      write_slot     <= '0;
      filled         <= '0;
      cand           <= '0;
      average_q16    <= '0;
      average_seeded <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          cmef_pkg::REG_MIN_LIMIT:      min_limit <= cfg_data[cmef_pkg::SAMPLE_W-1:0];
          cmef_pkg::REG_MAX_LIMIT:      max_limit <= cfg_data[cmef_pkg::SAMPLE_W-1:0];
          cmef_pkg::REG_WINDOW_LENGTH: begin
            window_length <= wl_wr;
            write_slot    <= '0;
            filled        <= '0;
          end
          cmef_pkg::REG_SMOOTHING_GAIN: smoothing_gain <= gain_wr;
          default: ;
        endcase
      end
      if (cmd.load) begin
        write_slot <= write_slot_next;
        filled     <= filled_next;
        cand       <= '0;
      end
      if (cmd.scan) cand <= cand + cmef_pkg::IDX_W'(1);
      if (cmd.seed) begin
        average_q16    <= {median, {cmef_pkg::FRAC_W{1'b0}}};
        average_seeded <= 1'b1;
      end
      if (cmd.accum) begin
        average_q16 <= average_q16 + prod_hi
                     + $signed({{cmef_pkg::SAMPLE_W{1'b0}}, prod_lo});
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      history[write_slot] <= clamp_v;
      clamp_reg           <= clamp_v;
    end
    if (cmd.scan && sts.found) median <= cand_val;
    if (cmd.diff) begin
      diff_hi <= diff[cmef_pkg::DIFF_W-1:cmef_pkg::FRAC_W];
      diff_lo <= diff[cmef_pkg::FRAC_W-1:0];
    end
    if (cmd.mul_hi) prod_hi <= product[cmef_pkg::AVG_W-1:0];
    if (cmd.mul_lo) prod_lo <= product[2*cmef_pkg::FRAC_W-1:cmef_pkg::FRAC_W];
    if (cmd.publish) begin
      clamped_value  <= clamp_reg;
      median_value   <= median;
      smoothed_value <= average_q16[cmef_pkg::AVG_W-1:cmef_pkg::FRAC_W];
      window_full    <= (filled >= window_length);
      fill_count     <= filled;
    end
  end

endmodule

@@ rtl/clamp_median_ewma_filter.sv @@
// ----------------------------------------------------------------------------
// clamp_median_ewma_filter
// sample clamp with invalid-sample midpoint, running upper median over a
// circular window of up to nine entries, and a q16.16 ewma of the median
// ----------------------------------------------------------------------------
//
//  channel   signals                                  direction
//  input     in_valid, in_stall, sample,              in (in_stall out)
//            sample_invalid
//  output    out_valid, out_stall, clamped_value,     out (out_stall in)
//            median_value, smoothed_value,
//            window_full, fill_count
//  config    cfg_write_en, cfg_index, cfg_data        in
//
//  one request at a time: accept, then a rank scan that checks one window
//  entry per cycle against all filled entries and stops at the first entry
//  that holds the median, then an ewma step, either a seed or a difference,
//  two halves on one shared 18x18 multiplier and an accumulate, then publish;
//  the block takes no new request until the request it holds is published
//  the output register lets the next request enter while a result waits;
//  publish waits only if the previous result has not yet been taken
//  rst is synchronous; it restores register defaults and clears the window
//  and ewma state, in_stall is held high while rst is asserted
//
module clamp_median_ewma_filter (
  input  logic                                  clk,
  input  logic                                  rst,
  // config write port
  input  logic                                  cfg_write_en,
  input  logic [cmef_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cmef_pkg::CFG_DATA_W-1:0]       cfg_data,
  // input requests
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [cmef_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  sample_invalid,
  // output results
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [cmef_pkg::SAMPLE_W-1:0]  clamped_value,
  output logic signed [cmef_pkg::SAMPLE_W-1:0]  median_value,
  output logic signed [cmef_pkg::SAMPLE_W-1:0]  smoothed_value,
  output logic                                  window_full,
  output logic [cmef_pkg::CNT_W-1:0]            fill_count
);

  // command and status between sequencer and datapath
  cmef_pkg::cmd_t cmd;
  cmef_pkg::sts_t sts;

  // sequencer owns the handshakes and the output valid flag
  cmef_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath holds config, window, ewma state and the result payload
  cmef_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample         (sample),
    .sample_invalid (sample_invalid),
    .clamped_value  (clamped_value),
    .median_value   (median_value),
    .smoothed_value (smoothed_value),
    .window_full    (window_full),
    .fill_count     (fill_count)
  );

endmodule

@@ rtl/cmef_checker.sv @@
// ----------------------------------------------------------------------------
// cmef_checker
// port-level checks on the filter, attached to the top level by bind
// ----------------------------------------------------------------------------
module cmef_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  cfg_write_en,
  input logic [cmef_pkg::CFG_IDX_W-1:0]        cfg_index,
  input logic [cmef_pkg::CFG_DATA_W-1:0]       cfg_data,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic signed [cmef_pkg::SAMPLE_W-1:0]  sample,
  input logic                                  sample_invalid,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [cmef_pkg::SAMPLE_W-1:0]  clamped_value,
  input logic signed [cmef_pkg::SAMPLE_W-1:0]  median_value,
  input logic signed [cmef_pkg::SAMPLE_W-1:0]  smoothed_value,
  input logic                                  window_full,
  input logic [cmef_pkg::CNT_W-1:0]            fill_count
);

  // no result is pending right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // a request occupies the block for at least the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted back to back");

  // a shown result always reports a nonempty window within range
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill_count != '0) &&
                  (fill_count <= cmef_pkg::CNT_W'(cmef_pkg::WINDOW_MAX)))
    else $error("fill_count out of range");

  // stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(clamped_value) &&
      $stable(median_value) && $stable(smoothed_value) &&
      $stable(window_full) && $stable(fill_count))
    else $error("stalled result changed");

endmodule

bind clamp_median_ewma_filter cmef_checker u_cmef_checker (.*);
